// File: sv/cic_pkg.sv
// ----------------------------------------------------------------------------
// cic_pkg - shared types and constants for the cascaded interrupt controller
// Item formats, operation codes, reset values and scan interface structs.
// ----------------------------------------------------------------------------
package cic_pkg;

  // Operation codes
  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_RAISE = 3'd2;
  localparam logic [2:0] OP_EOI   = 3'd3;
  localparam logic [2:0] OP_CHECK = 3'd4;

  // Chip indexes and port decode
  localparam logic       CHIP_MASTER    = 1'b0;
  localparam logic       CHIP_SLAVE     = 1'b1;
  localparam logic [3:0] MASTER_PORT_HI = 4'h2;
  localparam logic [3:0] PORT_CMD       = 4'h0;
  localparam logic [3:0] PORT_DATA      = 4'h1;
  localparam logic [2:0] CASCADE_LINE   = 3'd2;

  // Init sequence phases
  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_BASE    = 2'd1;
  localparam logic [1:0] PHASE_CASCADE = 2'd2;
  localparam logic [1:0] PHASE_MODE    = 2'd3;

  // Reset values and byte constants
  localparam logic [7:0] RESET_MASK_M = 8'hF8;
  localparam logic [7:0] RESET_MASK_S = 8'hFF;
  localparam logic [7:0] RESET_BASE_M = 8'h08;
  localparam logic [7:0] RESET_BASE_S = 8'h70;
  localparam logic [7:0] BASE_KEEP    = 8'hF8;
  localparam logic [7:0] EOI_SEL      = 8'hE0;
  localparam logic [7:0] EOI_LOW_A    = 8'h20;
  localparam logic [7:0] EOI_LOW_B    = 8'hA0;
  localparam logic [7:0] EOI_SPEC_A   = 8'h60;
  localparam logic [7:0] EOI_SPEC_B   = 8'hE0;
  localparam logic [7:0] LINE_SEL     = 8'h07;
  localparam logic [7:0] BAD_PORT     = 8'hFF;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] port;
    logic [7:0] write_data;
    logic [3:0] irq_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       interrupt_valid;
    logic [7:0] vector;
  } out_item_t;

  typedef struct packed {
    logic [7:0] req;
    logic [7:0] isr;
    logic [7:0] imr;
    logic       smm;
    logic       skip_cascade;
  } scan_in_t;

  typedef struct packed {
    logic       found;
    logic [2:0] line;
  } scan_out_t;

endpackage

// File: sv/cic_scan.sv
// ----------------------------------------------------------------------------
// cic_scan - fixed-priority line scan for one controller chip
// Finds the first unmasked requested line, honoring in-service blocking,
// special mask mode and the nested-mode cascade exemption.
// ----------------------------------------------------------------------------
module cic_scan (
  input  cic_pkg::scan_in_t  scan_in,
  output cic_pkg::scan_out_t scan_out
);
  import cic_pkg::*;

  logic stop;

  // Walk lines from 0 upward; stop at a blocking in-service line or a grant
  always_comb begin
    scan_out = '0;
    stop     = 1'b0;
    if (scan_in.req != 8'h00) begin
      for (int i = 0; i < 8; i++) begin
        if (!stop) begin
          if (!(scan_in.skip_cascade && (3'(i) == CASCADE_LINE)) && scan_in.isr[i]) begin
            if (!(scan_in.smm && scan_in.imr[i])) begin
              stop = 1'b1;
            end
          end else if (!scan_in.imr[i] && scan_in.req[i]) begin
            scan_out.found = 1'b1;
            scan_out.line  = 3'(i);
            stop           = 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: sv/cascaded_interrupt_controller_core.sv
// ----------------------------------------------------------------------------
// cascaded_interrupt_controller_core - master/slave interrupt controller pair
// Slave cascaded on master line 2; port accesses, line raises, direct
// end-of-interrupt and service checks, one result beat per input beat.
// ----------------------------------------------------------------------------
//  channel | signals                          | beat
//  --------+----------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data      | op, port, write_data, irq_line
//  output  | out_valid, out_ready, out_data   | read_data, interrupt_valid, vector
//
//  One beat per cycle sustained unless out_ready stalls; input register, then
//  result register. Each item's state update and result are formed in the
//  cycle it moves from the input register to the result register.
//  Reset restores both chips to their power-up masks and vector bases.
//  A stalled output holds its beat while the input register still accepts one.
// ----------------------------------------------------------------------------
module cascaded_interrupt_controller_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cic_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cic_pkg::out_item_t out_data
);
  import cic_pkg::*;

  // Pipeline registers
  logic      s1_valid;
  in_item_t  s1_data;
  logic      advance;
  out_item_t result_next;

  // Per-chip state, index 0 master, 1 slave
  logic [1:0] init_phase      [2];
  logic [7:0] vector_base     [2];
  logic       auto_end_mode   [2];
  logic       nested_mode     [2];
  logic       mask_mode       [2];
  logic       read_in_service [2];
  logic [7:0] line_mask       [2];
  logic [7:0] request_bits    [2];
  logic [7:0] service_bits    [2];
  logic [7:0] held_requests   [2];

  logic [1:0] init_phase_next      [2];
  logic [7:0] vector_base_next     [2];
  logic       auto_end_mode_next   [2];
  logic       nested_mode_next     [2];
  logic       mask_mode_next       [2];
  logic       read_in_service_next [2];
  logic [7:0] line_mask_next       [2];
  logic [7:0] request_bits_next    [2];
  logic [7:0] service_bits_next    [2];
  logic [7:0] held_requests_next   [2];

  // Decode of the registered item
  logic       chip;
  logic [3:0] low;
  logic [7:0] wbyte;
  logic       line_chip;
  logic [7:0] line_bit;
  logic [7:0] eoi_sel;

  // Scan wiring
  scan_in_t   slave_scan_in;
  scan_out_t  slave_scan_out;
  scan_in_t   master_scan_in;
  scan_out_t  master_scan_out;
  logic [7:0] master_req_raised;
  logic [7:0] master_held_raised;
  logic [7:0] master_bit;
  logic [7:0] slave_bit;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  assign chip      = (s1_data.port[7:4] == MASTER_PORT_HI) ? CHIP_MASTER : CHIP_SLAVE;
  assign low       = s1_data.port[3:0];
  assign wbyte     = s1_data.write_data;
  assign line_chip = s1_data.irq_line[3];
  assign line_bit  = 8'b1 << s1_data.irq_line[2:0];
  assign eoi_sel   = wbyte & EOI_SEL;

  // Slave scan first; a find raises master cascade line
  assign slave_scan_in.req          = request_bits[CHIP_SLAVE];
  assign slave_scan_in.isr          = service_bits[CHIP_SLAVE];
  assign slave_scan_in.imr          = line_mask[CHIP_SLAVE];
  assign slave_scan_in.smm          = mask_mode[CHIP_SLAVE];
  assign slave_scan_in.skip_cascade = 1'b0;

  always_comb begin
    master_req_raised  = request_bits[CHIP_MASTER];
    master_held_raised = held_requests[CHIP_MASTER];
    if (slave_scan_out.found) begin
      if (init_phase[CHIP_MASTER] != PHASE_IDLE) begin
        master_held_raised = master_held_raised | (8'b1 << CASCADE_LINE);
      end else begin
        master_req_raised = master_req_raised | (8'b1 << CASCADE_LINE);
      end
    end
  end

  assign master_scan_in.req          = master_req_raised;
  assign master_scan_in.isr          = service_bits[CHIP_MASTER];
  assign master_scan_in.imr          = line_mask[CHIP_MASTER];
  assign master_scan_in.smm          = mask_mode[CHIP_MASTER];
  assign master_scan_in.skip_cascade = nested_mode[CHIP_MASTER];

  assign master_bit = 8'b1 << master_scan_out.line;
  assign slave_bit  = 8'b1 << slave_scan_out.line;

  cic_scan u_scan_slave (
    .scan_in  (slave_scan_in),
    .scan_out (slave_scan_out)
  );

  cic_scan u_scan_master (
    .scan_in  (master_scan_in),
    .scan_out (master_scan_out)
  );

  // Form the next state and the result beat for the registered item
  always_comb begin
    init_phase_next      = init_phase;
    vector_base_next     = vector_base;
    auto_end_mode_next   = auto_end_mode;
    nested_mode_next     = nested_mode;
    mask_mode_next       = mask_mode;
    read_in_service_next = read_in_service;
    line_mask_next       = line_mask;
    request_bits_next    = request_bits;
    service_bits_next    = service_bits;
    held_requests_next   = held_requests;
    result_next          = '0;

    case (s1_data.op)
      OP_READ: begin
        if (low == PORT_CMD) begin
          result_next.read_data = read_in_service[chip] ? service_bits[chip]
                                                        : request_bits[chip];
        end else if (low == PORT_DATA) begin
          result_next.read_data = line_mask[chip];
        end else begin
          result_next.read_data = BAD_PORT;
        end
      end

      OP_WRITE: begin
        if (low == PORT_CMD) begin
          if (wbyte[4]) begin
            // Start init: clear masks and pending state
            init_phase_next[chip]      = PHASE_BASE;
            line_mask_next[chip]       = 8'h00;
            service_bits_next[chip]    = 8'h00;
            request_bits_next[chip]    = 8'h00;
            held_requests_next[chip]   = 8'h00;
            mask_mode_next[chip]       = 1'b0;
            read_in_service_next[chip] = 1'b0;
          end else if (wbyte[3]) begin
            if (wbyte[6]) begin
              mask_mode_next[chip] = wbyte[5];
            end
            if (wbyte[1]) begin
              read_in_service_next[chip] = wbyte[0];
            end
          end else if ((eoi_sel == EOI_LOW_A) || (eoi_sel == EOI_LOW_B)) begin
            // Drop the lowest in-service bit
            service_bits_next[chip] = service_bits[chip] & (service_bits[chip] - 8'd1);
          end else if ((eoi_sel == EOI_SPEC_A) || (eoi_sel == EOI_SPEC_B)) begin
            service_bits_next[chip] = service_bits[chip] &
                                      ~(8'b1 << (wbyte & LINE_SEL));
          end
        end else if (low == PORT_DATA) begin
          case (init_phase[chip])
            PHASE_BASE: begin
              vector_base_next[chip] = wbyte & BASE_KEEP;
              init_phase_next[chip]  = PHASE_CASCADE;
            end
            PHASE_CASCADE: begin
              init_phase_next[chip] = PHASE_MODE;
            end
            PHASE_MODE: begin
              auto_end_mode_next[chip] = wbyte[1];
              nested_mode_next[chip]   = wbyte[4];
              init_phase_next[chip]    = PHASE_IDLE;
              request_bits_next[chip]  = held_requests[chip];
            end
            default: begin
              line_mask_next[chip] = wbyte;
            end
          endcase
        end
      end

      OP_RAISE: begin
        if (init_phase[line_chip] != PHASE_IDLE) begin
          held_requests_next[line_chip] = held_requests[line_chip] | line_bit;
        end else begin
          request_bits_next[line_chip] = request_bits[line_chip] | line_bit;
        end
      end

      OP_EOI: begin
        service_bits_next[line_chip] = service_bits[line_chip] & ~line_bit;
        if ((line_chip == CHIP_SLAVE) &&
            ((service_bits[CHIP_SLAVE] & ~line_bit) == 8'h00)) begin
          service_bits_next[CHIP_MASTER] = service_bits[CHIP_MASTER] &
                                           ~(8'b1 << CASCADE_LINE);
        end
      end

      OP_CHECK: begin
        request_bits_next[CHIP_MASTER]  = master_req_raised;
        held_requests_next[CHIP_MASTER] = master_held_raised;
        if (master_scan_out.found) begin
          // Grant on the master
          request_bits_next[CHIP_MASTER] = master_req_raised & ~master_bit;
          if (!auto_end_mode[CHIP_MASTER]) begin
            service_bits_next[CHIP_MASTER] = service_bits[CHIP_MASTER] | master_bit;
          end
          if (master_scan_out.line == CASCADE_LINE) begin
            if (slave_scan_out.found) begin
              request_bits_next[CHIP_SLAVE] = request_bits[CHIP_SLAVE] & ~slave_bit;
              if (!auto_end_mode[CHIP_SLAVE]) begin
                service_bits_next[CHIP_SLAVE] = service_bits[CHIP_SLAVE] | slave_bit;
              end
              result_next.interrupt_valid = 1'b1;
              result_next.vector = vector_base[CHIP_SLAVE] + {5'd0, slave_scan_out.line};
            end
          end else begin
            result_next.interrupt_valid = 1'b1;
            result_next.vector = vector_base[CHIP_MASTER] + {5'd0, master_scan_out.line};
          end
        end
      end

      default: begin
        result_next = '0;
      end
    endcase
  end

  // Hold state, input register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        init_phase[c]      <= PHASE_IDLE;
        auto_end_mode[c]   <= 1'b0;
        nested_mode[c]     <= 1'b0;
        mask_mode[c]       <= 1'b0;
        read_in_service[c] <= 1'b0;
        request_bits[c]    <= 8'h00;
        service_bits[c]    <= 8'h00;
        held_requests[c]   <= 8'h00;
      end
      vector_base[CHIP_MASTER] <= RESET_BASE_M;
      vector_base[CHIP_SLAVE]  <= RESET_BASE_S;
      line_mask[CHIP_MASTER]   <= RESET_MASK_M;
      line_mask[CHIP_SLAVE]    <= RESET_MASK_S;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid       <= 1'b1;
        init_phase      <= init_phase_next;
        vector_base     <= vector_base_next;
        auto_end_mode   <= auto_end_mode_next;
        nested_mode     <= nested_mode_next;
        mask_mode       <= mask_mode_next;
        read_in_service <= read_in_service_next;
        line_mask       <= line_mask_next;
        request_bits    <= request_bits_next;
        service_bits    <= service_bits_next;
        held_requests   <= held_requests_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
    if (advance) begin
      out_data <= result_next;
    end
  end

`ifndef SYNTHESIS
  // A granted vector never carries read data
  a_grant_no_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.interrupt_valid |-> out_data.read_data == 8'h00)
    else $error("grant beat carries read data");

  // No vector without a grant
  a_vector_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.interrupt_valid |-> out_data.vector == 8'h00)
    else $error("vector set without grant");

  // During init requests only collect in the held register
  a_init_no_req_m: assert property (@(posedge clk) disable iff (rst)
    init_phase[CHIP_MASTER] != PHASE_IDLE |-> request_bits[CHIP_MASTER] == 8'h00)
    else $error("master request pending during init");

  a_init_no_req_s: assert property (@(posedge clk) disable iff (rst)
    init_phase[CHIP_SLAVE] != PHASE_IDLE |-> request_bits[CHIP_SLAVE] == 8'h00)
    else $error("slave request pending during init");

  // A new result beat comes only from a held input beat
  a_out_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result beat without input beat");
`endif

endmodule

// File: tb/tb_cascaded_interrupt_controller_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cascaded_interrupt_controller_core - self-checking bench for the PIC pair
// Walks a table of directed beats, then random bus traffic with init
// sequences, line raises and service checks, against fixed expectations or a
// behavioral model of the pair kept in the bench. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_cascaded_interrupt_controller_core;
  import cic_pkg::*;

  localparam int         RANDOM_BEATS  = 600;
  localparam int         HOLD_CYCLES   = 120;
  localparam logic [2:0] OP_SPARE_LO   = 3'd5;
  localparam logic [2:0] OP_SPARE_HI   = 3'd7;
  localparam logic [3:0] SLAVE_PORT_HI = 4'hA;
  localparam logic [7:0] M_CMD         = {MASTER_PORT_HI, PORT_CMD};
  localparam logic [7:0] M_DATA        = {MASTER_PORT_HI, PORT_DATA};
  localparam logic [7:0] M_SPARE       = 8'h2F;
  localparam logic [7:0] S_CMD         = {SLAVE_PORT_HI, PORT_CMD};
  localparam logic [7:0] S_DATA        = {SLAVE_PORT_HI, PORT_DATA};
  localparam logic [7:0] CMD_INIT      = 8'h10;
  localparam logic [7:0] CMD_SELECT    = 8'h08;
  localparam logic [7:0] SEL_READ_ISR  = 8'h03;
  localparam logic [7:0] SEL_SMM_ON    = 8'h60;
  localparam logic [7:0] MODE_AEOI     = 8'h02;
  localparam logic [7:0] MODE_NESTED   = 8'h10;

  typedef struct packed {
    in_item_t  beat;
    logic      fixed;
    out_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Model state per chip, index 0 master, 1 slave
  logic [1:0] pic_phase [2];
  logic [7:0] pic_base  [2];
  logic       pic_aeoi  [2];
  logic       pic_sfnm  [2];
  logic       pic_smm   [2];
  logic       pic_ris   [2];
  logic [7:0] pic_imr   [2];
  logic [7:0] pic_irr   [2];
  logic [7:0] pic_isr   [2];
  logic [7:0] pic_held  [2];

  out_item_t pending_results [$];
  stim_row_t directed_rows [$];
  in_item_t  traffic_q [$];
  int        err_count;
  int        accepted_beats;
  int        burst_left;

  cascaded_interrupt_controller_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Behavioral model of the pair
  // ---------------------------------------------------------------------------
  function automatic void pic_pair_reset();
    for (int c = 0; c < 2; c++) begin
      pic_phase[c] = PHASE_IDLE;
      pic_aeoi[c]  = 1'b0;
      pic_sfnm[c]  = 1'b0;
      pic_smm[c]   = 1'b0;
      pic_ris[c]   = 1'b0;
      pic_irr[c]   = 8'h00;
      pic_isr[c]   = 8'h00;
      pic_held[c]  = 8'h00;
    end
    pic_base[CHIP_MASTER] = RESET_BASE_M;
    pic_base[CHIP_SLAVE]  = RESET_BASE_S;
    pic_imr[CHIP_MASTER]  = RESET_MASK_M;
    pic_imr[CHIP_SLAVE]   = RESET_MASK_S;
  endfunction

  function automatic void raise_request(input logic chip, input logic [2:0] line);
    if (pic_phase[chip] != PHASE_IDLE) pic_held[chip][line] = 1'b1;
    else pic_irr[chip][line] = 1'b1;
  endfunction

  // Fixed-priority scan; -1 when nothing can be granted
  function automatic int scan_pic(input logic chip);
    logic skip_service;
    if (pic_irr[chip] == 8'h00) return -1;
    for (int i = 0; i < 8; i++) begin
      skip_service = (chip == CHIP_MASTER) && (i == CASCADE_LINE) && pic_sfnm[CHIP_MASTER];
      if (!skip_service && pic_isr[chip][i]) begin
        // in-service line blocks lower priorities unless special mask hides it
        if (!(pic_smm[chip] && pic_imr[chip][i])) return -1;
      end else if (!pic_imr[chip][i] && pic_irr[chip][i]) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void grant_line(input logic chip, input int line);
    pic_irr[chip][line] = 1'b0;
    if (!pic_aeoi[chip]) pic_isr[chip][line] = 1'b1;
  endfunction

  function automatic void program_port(input logic chip, input logic [3:0] low,
                                       input logic [7:0] v);
    logic [7:0] sel;
    sel = v & EOI_SEL;
    if (low == PORT_CMD) begin
      if (v[4]) begin
        // start init: clear the live registers, keep base, auto-EOI and nested mode
        pic_phase[chip] = PHASE_BASE;
        pic_imr[chip]   = 8'h00;
        pic_isr[chip]   = 8'h00;
        pic_irr[chip]   = 8'h00;
        pic_held[chip]  = 8'h00;
        pic_smm[chip]   = 1'b0;
        pic_ris[chip]   = 1'b0;
      end else if (v[3]) begin
        if (v[6]) pic_smm[chip] = v[5];
        if (v[1]) pic_ris[chip] = v[0];
      end else if (sel == EOI_LOW_A || sel == EOI_LOW_B) begin
        pic_isr[chip] = pic_isr[chip] & (pic_isr[chip] - 8'd1);
      end else if (sel == EOI_SPEC_A || sel == EOI_SPEC_B) begin
        pic_isr[chip][v[2:0]] = 1'b0;
      end
    end else if (low == PORT_DATA) begin
      case (pic_phase[chip])
        PHASE_BASE: begin
          pic_base[chip]  = v & BASE_KEEP;
          pic_phase[chip] = PHASE_CASCADE;
        end
        PHASE_CASCADE: pic_phase[chip] = PHASE_MODE;
        PHASE_MODE: begin
          pic_aeoi[chip]  = v[1];
          pic_sfnm[chip]  = v[4];
          pic_phase[chip] = PHASE_IDLE;
          pic_irr[chip]   = pic_held[chip];
        end
        default: pic_imr[chip] = v;
      endcase
    end
  endfunction

  function automatic out_item_t pic_pair_step(input in_item_t b);
    out_item_t  res;
    logic       chip;
    logic [3:0] low;
    int         s;
    int         m;
    res  = '0;
    chip = (b.port[7:4] == MASTER_PORT_HI) ? CHIP_MASTER : CHIP_SLAVE;
    low  = b.port[3:0];
    case (b.op)
      OP_READ: begin
        if (low == PORT_CMD) res.read_data = pic_ris[chip] ? pic_isr[chip] : pic_irr[chip];
        else if (low == PORT_DATA) res.read_data = pic_imr[chip];
        else res.read_data = BAD_PORT;
      end
      OP_WRITE: program_port(chip, low, b.write_data);
      OP_RAISE: raise_request(b.irq_line[3], b.irq_line[2:0]);
      OP_EOI: begin
        pic_isr[b.irq_line[3]][b.irq_line[2:0]] = 1'b0;
        if (b.irq_line[3] == CHIP_SLAVE && pic_isr[CHIP_SLAVE] == 8'h00)
          pic_isr[CHIP_MASTER][CASCADE_LINE] = 1'b0;
      end
      OP_CHECK: begin
        // slave scan only raises the cascade line; master decides the grant
        s = scan_pic(CHIP_SLAVE);
        if (s >= 0) raise_request(CHIP_MASTER, CASCADE_LINE);
        m = scan_pic(CHIP_MASTER);
        if (m >= 0) begin
          grant_line(CHIP_MASTER, m);
          if (m == CASCADE_LINE) begin
            if (s >= 0) begin
              grant_line(CHIP_SLAVE, s);
              res.interrupt_valid = 1'b1;
              res.vector          = pic_base[CHIP_SLAVE] + 8'(s);
            end
          end else begin
            res.interrupt_valid = 1'b1;
            res.vector          = pic_base[CHIP_MASTER] + 8'(m);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk_beat(input logic [2:0] op, input logic [7:0] port,
                                       input logic [7:0] data, input logic [3:0] line);
    in_item_t b;
    b.op         = op;
    b.port       = port;
    b.write_data = data;
    b.irq_line   = line;
    return b;
  endfunction

  task automatic add_row(input logic [2:0] op, input logic [7:0] port,
                         input logic [7:0] data, input logic [3:0] line,
                         input logic fixed, input logic [7:0] rd,
                         input logic iv, input logic [7:0] vec);
    stim_row_t r;
    r.beat                 = mk_beat(op, port, data, line);
    r.fixed                = fixed;
    r.want.read_data       = rd;
    r.want.interrupt_valid = iv;
    r.want.vector          = vec;
    directed_rows.push_back(r);
  endtask

  function automatic logic [7:0] pick_port();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return {MASTER_PORT_HI, 3'b000, 1'($urandom)};
    if (r < 80) return {SLAVE_PORT_HI, 3'b000, 1'($urandom)};
    return 8'($urandom);
  endfunction

  // Queue one random beat, or a whole (possibly cut short) init sequence
  task automatic queue_random_traffic();
    int         r;
    int         nbytes;
    logic [3:0] hi;
    logic [7:0] port;
    logic [7:0] data;
    r    = $urandom_range(0, 99);
    port = pick_port();
    data = 8'($urandom);
    if (r < 7) begin
      hi = $urandom_range(0, 1) ? MASTER_PORT_HI : SLAVE_PORT_HI;
      traffic_q.push_back(mk_beat(OP_WRITE, {hi, PORT_CMD}, 8'($urandom) | CMD_INIT,
                                  4'($urandom)));
      nbytes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : 3;
      for (int k = 0; k < nbytes; k++) begin
        if ($urandom_range(0, 9) < 3)
          traffic_q.push_back(mk_beat(OP_RAISE, 8'($urandom), 8'($urandom), 4'($urandom)));
        traffic_q.push_back(mk_beat(OP_WRITE, {hi, PORT_DATA}, 8'($urandom), 4'($urandom)));
      end
    end else if (r < 29) begin
      traffic_q.push_back(mk_beat(OP_RAISE, port, data, 4'($urandom)));
    end else if (r < 51) begin
      traffic_q.push_back(mk_beat(OP_CHECK, port, data, 4'($urandom)));
    end else if (r < 61) begin
      traffic_q.push_back(mk_beat(OP_READ, port, data, 4'($urandom)));
    end else if (r < 71) begin
      traffic_q.push_back(mk_beat(OP_EOI, port, data, 4'($urandom)));
    end else if (r < 74) begin
      traffic_q.push_back(mk_beat(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), port, data,
                                  4'($urandom)));
    end else begin
      r = $urandom_range(0, 9);
      if (port[3:0] == PORT_CMD) begin
        if (r < 4) data = (data & 8'hE7) | CMD_SELECT;
        else if (r < 9) data = data & 8'hE7;
      end else if (r < 8) begin
        // sparse masks keep most lines open
        data = data & 8'($urandom);
      end
      traffic_q.push_back(mk_beat(OP_WRITE, port, data, 4'($urandom)));
    end
  endtask

  // Present one beat at a falling edge, hold until taken, then maybe idle
  task automatic send_beat(input in_item_t b, input logic fixed, input out_item_t want,
                           input logic last_beat);
    out_item_t predicted;
    int        gap;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    predicted = pic_pair_step(b);
    pending_results.push_back(fixed ? want : predicted);
    accepted_beats++;
    @(negedge clk);
    if (last_beat) begin
      in_valid <= 1'b0;
    end else if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 20);
      repeat (gap) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender and sequencing
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t b;
    int       sent;
    in_valid       <= 1'b0;
    in_data        <= '0;
    rst            <= 1'b1;
    err_count      = 0;
    accepted_beats = 0;
    burst_left     = 0;
    pic_pair_reset();

    // power-up reads, spare ops, cascade and init corner cases
    add_row(OP_READ,     M_DATA,  8'h00, 4'h0, 1'b1, RESET_MASK_M, 1'b0, 8'h00);
    add_row(OP_READ,     S_DATA,  8'h00, 4'h0, 1'b1, RESET_MASK_S, 1'b0, 8'h00);
    add_row(OP_READ,     M_SPARE, 8'h00, 4'h0, 1'b1, BAD_PORT,     1'b0, 8'h00);
    add_row(OP_READ,     M_CMD,   8'hFF, 4'hF, 1'b1, 8'h00,        1'b0, 8'h00);
    add_row(OP_CHECK,    S_CMD,   8'h00, 4'h0, 1'b1, 8'h00,        1'b0, 8'h00);
    add_row(OP_SPARE_HI, 8'hFF,   8'hFF, 4'hF, 1'b1, 8'h00,        1'b0, 8'h00);
    add_row(OP_RAISE,    M_CMD,   8'h00, 4'h0, 1'b0, 8'h00,        1'b0, 8'h00);
    add_row(OP_CHECK,    M_CMD,   8'h00, 4'h0, 1'b1, 8'h00,        1'b1, RESET_BASE_M);
    add_row(OP_RAISE,    M_CMD,   8'h00, 4'hF, 1'b0, 8'h00,        1'b0, 8'h00);
    add_row(OP_WRITE,    S_DATA,  8'h00, 4'h0, 1'b0, 8'h00,        1'b0, 8'h00);
    add_row(OP_CHECK,    M_CMD,   8'h00, 4'h0, 1'b0, 8'h00,        1'b0, 8'h00);
    add_row(OP_WRITE,    M_CMD,   EOI_SPEC_A, 4'h0, 1'b0, 8'h00,   1'b0, 8'h00);
    add_row(OP_CHECK,    M_CMD,   8'h00, 4'h0, 1'b0, 8'h00,        1'b0, 8'h00);
    add_row(OP_WRITE,    M_CMD,   CMD_SELECT | SEL_READ_ISR, 4'h0, 1'b0, 8'h00, 1'b0, 8'h00);
    add_row(OP_READ,     M_CMD,   8'h00, 4'h0, 1'b0, 8'h00,        1'b0, 8'h00);
    add_row(OP_EOI,      M_CMD,   8'h00, 4'hF, 1'b0, 8'h00,        1'b0, 8'h00);
    add_row(OP_READ,     M_CMD,   8'h00, 4'h0, 1'b0, 8'h00,        1'b0, 8'h00);
    add_row(OP_WRITE,    M_CMD,   CMD_INIT, 4'h0, 1'b0, 8'h00,     1'b0, 8'h00);
    add_row(OP_RAISE,    M_CMD,   8'h00, 4'h1, 1'b0, 8'h00,        1'b0, 8'h00);
    add_row(OP_WRITE,    M_DATA,  8'hFF, 4'h0, 1'b0, 8'h00,        1'b0, 8'h00);
    add_row(OP_WRITE,    M_DATA,  8'h04, 4'h0, 1'b0, 8'h00,        1'b0, 8'h00);
    add_row(OP_WRITE,    M_DATA,  MODE_AEOI | MODE_NESTED, 4'h0, 1'b0, 8'h00, 1'b0, 8'h00);
    add_row(OP_CHECK,    M_CMD,   8'h00, 4'h0, 1'b0, 8'h00,        1'b0, 8'h00);
    add_row(OP_WRITE,    S_CMD,   CMD_SELECT | SEL_SMM_ON, 4'h0, 1'b0, 8'h00, 1'b0, 8'h00);
    add_row(OP_WRITE,    M_CMD,   EOI_LOW_A, 4'h0, 1'b0, 8'h00,    1'b0, 8'h00);
    add_row(OP_WRITE,    M_SPARE, 8'hFF, 4'h0, 1'b0, 8'h00,        1'b0, 8'h00);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].fixed, directed_rows[i].want, 1'b0);

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      if (traffic_q.size() == 0) queue_random_traffic();
      b = traffic_q.pop_front();
      sent++;
      send_beat(b, 1'b0, '0, sent == RANDOM_BEATS);
    end

    // drain, then allow the pipeline latency to settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("cascaded_interrupt_controller_core verification clean");
    end else begin
      $display("cascaded_interrupt_controller_core verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall modes plus one long hold-off to back up the input
  // ---------------------------------------------------------------------------
  initial begin
    int  rx_mode;
    int  rx_left;
    bit  hold_done;
    out_ready <= 1'b0;
    rx_mode   = 0;
    rx_left   = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && accepted_beats >= 200) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_left = $urandom_range(20, 80);
        end
        rx_left--;
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t due;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: actual %h", $time, out_data);
        err_count++;
      end else begin
        due = pending_results.pop_front();
        if (out_data.read_data !== due.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, due.read_data,
                   out_data.read_data);
          err_count++;
        end
        if (out_data.interrupt_valid !== due.interrupt_valid) begin
          $display("%0t: interrupt_valid expected %b actual %b", $time,
                   due.interrupt_valid, out_data.interrupt_valid);
          err_count++;
        end
        if (out_data.vector !== due.vector) begin
          $display("%0t: vector expected %h actual %h", $time, due.vector, out_data.vector);
          err_count++;
        end
      end
    end
  end

  // Hard stop if the handshake ever hangs
  initial begin
    #1_000_000;
    $display("cascaded_interrupt_controller_core verification failed");
    $finish;
  end

endmodule
